// ----- rtl/hahmc_pkg.sv -----
// Shared types, codes and constants for the hot-air heater mode controller.
// Used by the update logic, the top level and the testbench.
package hahmc_pkg;

  // Event codes carried by an input beat; code 7 is unused and changes nothing
  typedef enum logic [2:0] {
    CMD_ON        = 3'd0,
    CMD_OFF       = 3'd1,
    CMD_FIX       = 3'd2,
    CMD_FAN_KNOB  = 3'd3,
    CMD_TEMP_KNOB = 3'd4,
    CMD_STAND     = 3'd5,
    CMD_COOL_POLL = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_HOLDER = 2'd2,
    MODE_FIXED  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAGE_OFF  = 2'd0,
    STAGE_HEAT = 2'd1,
    STAGE_COOL = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    BEEP_NONE   = 2'd0,
    BEEP_SLEEP  = 2'd1,
    BEEP_COOLED = 2'd2
  } beep_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_COOL_THR         = 3'd0;
  localparam logic [2:0] CFG_SETPOINT_MIN     = 3'd1;
  localparam logic [2:0] CFG_SETPOINT_MAX     = 3'd2;
  localparam logic [2:0] CFG_FAN_DEFAULT      = 3'd3;
  localparam logic [2:0] CFG_SETPOINT_DEFAULT = 3'd4;

  // Reset values
  localparam logic [9:0] COOL_THR_RESET     = 10'd50;
  localparam logic [9:0] SETPOINT_MIN_RESET = 10'd100;
  localparam logic [9:0] SETPOINT_MAX_RESET = 10'd480;
  localparam logic [6:0] FAN_RESET          = 7'd60;
  localparam logic [9:0] SETPOINT_RESET     = 10'd200;

  // Knob limits and steps
  localparam logic [6:0] FAN_MAX       = 7'd100;
  localparam logic [6:0] FAN_MIN       = 7'd20;
  localparam logic [9:0] SETPOINT_STEP = 10'd5;
  localparam logic [9:0] SETPOINT_TOP  = 10'd1023;

  // Reciprocal of 20 in 12 fraction bits; exact for every 7-bit percent
  localparam logic [7:0] RECIP_20 = 8'd205;

  typedef struct packed {
    logic [2:0] cmd;
    logic       clockwise;
    logic       handle_lifted;
    logic       menu_level_three;
    logic [9:0] current_temp;
  } in_item_t;

  typedef struct packed {
    mode_e      power_mode;
    stage_e     heat_stage;
    logic [6:0] fan_percent;
    logic [7:0] fan_compare;
    logic [9:0] setpoint;
    logic       heat_pwm_enable;
    logic       fan_pwm_enable;
    logic       led_on;
    beep_e      beep_code;
    logic       hist_clear;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [9:0] value;
  } cfg_item_t;

  // Controller state carried between events
  typedef struct packed {
    mode_e      mode;
    stage_e     stage;
    logic [6:0] fan;
    logic [6:0] fan_saved;
    logic [9:0] setpoint;
    logic       led;
    logic       heat_en;
    logic       fan_en;
  } ctrl_state_t;

  // Settings the update logic reads
  typedef struct packed {
    logic [9:0] cool_thr;
    logic [9:0] setpoint_min;
    logic [9:0] setpoint_max;
  } ctrl_cfg_t;

  // Fan PWM compare: fan*2 + fan/2 + fan/20, wrapped to 8 bits
  function automatic logic [7:0] fan_compare_f(input logic [6:0] fan);
    logic [14:0] prod;
    logic [8:0]  sum;
    prod = fan * RECIP_20;
    sum  = {1'b0, fan, 1'b0} + {3'b000, fan[6:1]} + {6'b000000, prod[14:12]};
    return sum[7:0];
  endfunction

endpackage

// ----- rtl/hahmc_stream_if.sv -----
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is given per instance; depends on nothing else.
interface hahmc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/hahmc_update.sv -----
// Next-state logic of the mode controller for one event.
// Depends on hahmc_pkg for the state, item and code types.
module hahmc_update import hahmc_pkg::*; (
  input  ctrl_state_t state_i,
  input  ctrl_cfg_t   cfg_i,
  input  in_item_t    item_i,
  output ctrl_state_t state_o,
  output beep_e       beep_o,
  output logic        hist_clear_o
);

  logic        below_thr;
  logic [10:0] sp_up;

  assign below_thr = item_i.current_temp < cfg_i.cool_thr;
  assign sp_up     = {1'b0, state_i.setpoint} + {1'b0, SETPOINT_STEP};

  always_comb begin
    state_o      = state_i;
    beep_o       = BEEP_NONE;
    hist_clear_o = 1'b0;

    case (item_i.cmd) inside
      CMD_ON: begin
        state_o.mode    = MODE_ON;
        state_o.stage   = STAGE_HEAT;
        state_o.led     = 1'b1;
        state_o.fan_en  = 1'b1;
        state_o.heat_en = 1'b1;
        hist_clear_o    = 1'b1;
      end
      CMD_OFF, CMD_FIX: begin
        if (item_i.cmd == CMD_FIX && state_i.mode != MODE_FIXED) begin
          // enter fixed power, regulator history kept
          state_o.mode    = MODE_FIXED;
          state_o.stage   = STAGE_HEAT;
          state_o.led     = 1'b1;
          state_o.fan_en  = 1'b1;
          state_o.heat_en = 1'b1;
        end else begin
          // power off; start cooldown only when hot and handle up or menu deep
          state_o.mode    = MODE_OFF;
          state_o.heat_en = 1'b0;
          state_o.led     = 1'b0;
          if (below_thr) begin
            state_o.fan_en = 1'b0;
          end else if (item_i.handle_lifted || item_i.menu_level_three) begin
            state_o.fan_saved = state_i.fan;
            state_o.fan       = FAN_MAX;
            state_o.stage     = STAGE_COOL;
          end
        end
      end
      CMD_FAN_KNOB: begin
        if (item_i.clockwise) begin
          if (state_i.fan < FAN_MAX) state_o.fan = state_i.fan + 7'd1;
        end else begin
          if (state_i.fan > FAN_MIN) state_o.fan = state_i.fan - 7'd1;
        end
      end
      CMD_TEMP_KNOB: begin
        // step by five, saturate at the ends of the 10-bit range
        if (item_i.clockwise) begin
          if (state_i.setpoint < cfg_i.setpoint_max) begin
            state_o.setpoint = sp_up[10] ? SETPOINT_TOP : sp_up[9:0];
          end
        end else begin
          if (state_i.setpoint > cfg_i.setpoint_min) begin
            state_o.setpoint = (state_i.setpoint >= SETPOINT_STEP) ?
                               state_i.setpoint - SETPOINT_STEP : 10'd0;
          end
        end
      end
      CMD_STAND: begin
        if (!item_i.handle_lifted) begin
          if (state_i.mode == MODE_ON) begin
            // put to sleep on the stand
            state_o.mode      = MODE_HOLDER;
            state_o.stage     = STAGE_COOL;
            state_o.heat_en   = 1'b0;
            state_o.fan_saved = state_i.fan;
            state_o.fan       = FAN_MAX;
            beep_o            = BEEP_SLEEP;
          end else if (state_i.mode == MODE_HOLDER && state_i.stage != STAGE_COOL) begin
            state_o.led = ~state_i.led;
          end
        end else if (state_i.mode == MODE_HOLDER) begin
          // wake on lift
          state_o.fan     = state_i.fan_saved;
          state_o.mode    = MODE_ON;
          state_o.stage   = STAGE_HEAT;
          state_o.led     = 1'b1;
          state_o.fan_en  = 1'b1;
          state_o.heat_en = 1'b1;
          hist_clear_o    = 1'b1;
        end
      end
      CMD_COOL_POLL: begin
        if (state_i.stage == STAGE_COOL) begin
          if (below_thr) begin
            state_o.stage  = STAGE_OFF;
            state_o.fan    = state_i.fan_saved;
            state_o.led    = 1'b0;
            state_o.fan_en = 1'b0;
            beep_o         = BEEP_COOLED;
          end else begin
            state_o.led = ~state_i.led;
          end
        end
      end
      default: begin
        // unused code: report the state unchanged
      end
    endcase
  end

endmodule

// ----- rtl/hot_air_heater_mode_controller.sv -----
// Top level of the hot-air heater mode controller: channels, settings,
// input and result registers. Depends on hahmc_pkg, hahmc_stream_if, hahmc_update.
//
//   Channel  Dir  Payload     Meaning
//   in_i     in   in_item_t   one event per beat
//   out_o    out  out_item_t  state after the event plus pulses, one per event
//   cfg_i    in   cfg_item_t  settings write: register index and value
//
// An event passes from the input register to the result register; the block takes
// one event per cycle while the receiver takes each result as it appears.
// The state update is a single pass of hahmc_update between the two registers.
// A held result stalls the input register, which still takes one more beat.
// Reset loads the power-up settings and the off state.
module hot_air_heater_mode_controller import hahmc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  hahmc_stream_if.sink   in_i,
  hahmc_stream_if.source out_o,
  hahmc_stream_if.sink   cfg_i
);

  logic        in_valid_q;
  in_item_t    in_q;
  logic        out_valid_q;
  out_item_t   out_q;
  ctrl_state_t state_q;
  ctrl_state_t state_d;
  ctrl_cfg_t   cfg_q;
  beep_e       beep;
  logic        hist_clear;
  logic        advance;

  // Move the held event into the result register when that register frees
  assign advance     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready  = ~in_valid_q | advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // Settings; writes to the fan and setpoint defaults are ignored, reset loads fixed values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cool_thr     <= COOL_THR_RESET;
      cfg_q.setpoint_min <= SETPOINT_MIN_RESET;
      cfg_q.setpoint_max <= SETPOINT_MAX_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index) inside
        CFG_COOL_THR:                          cfg_q.cool_thr     <= cfg_i.data.value;
        CFG_SETPOINT_MIN:                      cfg_q.setpoint_min <= cfg_i.data.value;
        CFG_SETPOINT_MAX:                      cfg_q.setpoint_max <= cfg_i.data.value;
        CFG_FAN_DEFAULT, CFG_SETPOINT_DEFAULT: ;
        default:                               ;
      endcase
    end
  end

  hahmc_update u_update (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .item_i       (in_q),
    .state_o      (state_d),
    .beep_o       (beep),
    .hist_clear_o (hist_clear)
  );

  // Commit the new state with the event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= MODE_OFF;
      state_q.stage     <= STAGE_OFF;
      state_q.fan       <= FAN_RESET;
      state_q.fan_saved <= FAN_RESET;
      state_q.setpoint  <= SETPOINT_RESET;
      state_q.led       <= 1'b0;
      state_q.heat_en   <= 1'b0;
      state_q.fan_en    <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.power_mode      <= state_d.mode;
      out_q.heat_stage      <= state_d.stage;
      out_q.fan_percent     <= state_d.fan;
      out_q.fan_compare     <= fan_compare_f(state_d.fan);
      out_q.setpoint        <= state_d.setpoint;
      out_q.heat_pwm_enable <= state_d.heat_en;
      out_q.fan_pwm_enable  <= state_d.fan_en;
      out_q.led_on          <= state_d.led;
      out_q.beep_code       <= beep;
      out_q.hist_clear      <= hist_clear;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ----- tb/hahmc_status_check.sv -----
// Status checker for the hot-air heater mode controller testbench.
// Watches the event, status and settings channels; depends on hahmc_pkg.
module hahmc_status_check import hahmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      ev_valid_i,
  input  logic      ev_ready_i,
  input  in_item_t  ev_data_i,
  input  logic      status_valid_i,
  input  logic      status_ready_i,
  input  out_item_t status_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_item_t cfg_data_i,
  output int        due_count_o,
  output int        mismatch_count_o
);

  // Settings as the controller holds them; writes to the fan and setpoint defaults
  // never take effect, as the controller ignores them
  logic [9:0] cool_thr;
  logic [9:0] sp_min;
  logic [9:0] sp_max;

  // Predicted controller state and the pulses of the current event
  mode_e      mode;
  stage_e     stage;
  logic [6:0] fan;
  logic [6:0] fan_kept;
  logic [9:0] setpoint;
  logic       led;
  logic       heat_en;
  logic       fan_en;
  beep_e      beep;
  logic       clear_pulse;

  // Status beats predicted but not yet seen
  out_item_t  due_status_q[$];
  int         mismatches;

  function automatic void power_up();
    mode        = MODE_ON;
    stage       = STAGE_HEAT;
    led         = 1'b1;
    fan_en      = 1'b1;
    heat_en     = 1'b1;
    clear_pulse = 1'b1;
  endfunction

  // Heater off; a hot heater lifted or in menu level three starts cooling
  function automatic void power_down(input in_item_t ev);
    mode    = MODE_OFF;
    heat_en = 1'b0;
    if (ev.current_temp < cool_thr) begin
      fan_en = 1'b0;
    end else if (ev.handle_lifted || ev.menu_level_three) begin
      fan_kept = fan;
      fan      = FAN_MAX;
      stage    = STAGE_COOL;
    end
    led = 1'b0;
  endfunction

  // Advance the predicted state by one event and form its status beat
  function automatic out_item_t apply_event(input in_item_t ev);
    out_item_t rep;
    int        f;
    beep        = BEEP_NONE;
    clear_pulse = 1'b0;
    case (ev.cmd)
      CMD_ON: power_up();
      CMD_OFF: power_down(ev);
      CMD_FIX: begin
        if (mode != MODE_FIXED) begin
          mode    = MODE_FIXED;
          stage   = STAGE_HEAT;
          led     = 1'b1;
          fan_en  = 1'b1;
          heat_en = 1'b1;
        end else begin
          power_down(ev);
        end
      end
      CMD_FAN_KNOB: begin
        if (ev.clockwise) begin
          if (fan < FAN_MAX) fan = fan + 7'd1;
        end else if (fan > FAN_MIN) begin
          fan = fan - 7'd1;
        end
      end
      CMD_TEMP_KNOB: begin
        if (ev.clockwise) begin
          if (setpoint < sp_max) begin
            setpoint = (setpoint > SETPOINT_TOP - SETPOINT_STEP) ? SETPOINT_TOP
                                                                 : setpoint + SETPOINT_STEP;
          end
        end else if (setpoint > sp_min) begin
          setpoint = (setpoint >= SETPOINT_STEP) ? setpoint - SETPOINT_STEP : 10'd0;
        end
      end
      CMD_STAND: begin
        if (!ev.handle_lifted) begin
          // Put on the stand: sleep when on, blink when asleep and cooled
          if (mode == MODE_ON) begin
            mode     = MODE_HOLDER;
            stage    = STAGE_COOL;
            heat_en  = 1'b0;
            fan_kept = fan;
            fan      = FAN_MAX;
            beep     = BEEP_SLEEP;
          end else if (mode == MODE_HOLDER && stage != STAGE_COOL) begin
            led = ~led;
          end
        end else if (mode == MODE_HOLDER) begin
          fan = fan_kept;
          power_up();
        end
      end
      CMD_COOL_POLL: begin
        if (stage == STAGE_COOL) begin
          if (ev.current_temp < cool_thr) begin
            stage  = STAGE_OFF;
            fan    = fan_kept;
            led    = 1'b0;
            fan_en = 1'b0;
            beep   = BEEP_COOLED;
          end else begin
            led = ~led;
          end
        end
      end
      default: ;
    endcase
    f                   = fan;
    rep.power_mode      = mode;
    rep.heat_stage      = stage;
    rep.fan_percent     = fan;
    rep.fan_compare     = 8'(2 * f + f / 2 + f / 20);
    rep.setpoint        = setpoint;
    rep.heat_pwm_enable = heat_en;
    rep.fan_pwm_enable  = fan_en;
    rep.led_on          = led;
    rep.beep_code       = beep;
    rep.hist_clear      = clear_pulse;
    return rep;
  endfunction

  function automatic int field_differs(input string name, input int want, input int got);
    if (want == got) return 0;
    $display("%0t: status field %s expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cool_thr    = COOL_THR_RESET;
      sp_min      = SETPOINT_MIN_RESET;
      sp_max      = SETPOINT_MAX_RESET;
      mode        = MODE_OFF;
      stage       = STAGE_OFF;
      fan         = FAN_RESET;
      fan_kept    = FAN_RESET;
      setpoint    = SETPOINT_RESET;
      led         = 1'b0;
      heat_en     = 1'b0;
      fan_en      = 1'b0;
      due_status_q.delete();
      mismatches  = 0;
    end else begin
      // Compare a status beat with the oldest prediction
      if (status_valid_i && status_ready_i) begin
        if (due_status_q.size() == 0) begin
          $display("%0t: status beat expected none, got %p", $time, status_data_i);
          mismatches++;
        end else begin
          want = due_status_q.pop_front();
          mismatches += field_differs("power_mode", want.power_mode,
                                      status_data_i.power_mode)
                      + field_differs("heat_stage", want.heat_stage,
                                      status_data_i.heat_stage)
                      + field_differs("fan_percent", want.fan_percent,
                                      status_data_i.fan_percent)
                      + field_differs("fan_compare", want.fan_compare,
                                      status_data_i.fan_compare)
                      + field_differs("setpoint", want.setpoint, status_data_i.setpoint)
                      + field_differs("heat_pwm_enable", want.heat_pwm_enable,
                                      status_data_i.heat_pwm_enable)
                      + field_differs("fan_pwm_enable", want.fan_pwm_enable,
                                      status_data_i.fan_pwm_enable)
                      + field_differs("led_on", want.led_on, status_data_i.led_on)
                      + field_differs("beep_code", want.beep_code, status_data_i.beep_code)
                      + field_differs("hist_clear", want.hist_clear,
                                      status_data_i.hist_clear);
        end
      end
      // Track settings writes; the default registers change nothing
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.index)
          CFG_COOL_THR:     cool_thr = cfg_data_i.value;
          CFG_SETPOINT_MIN: sp_min   = cfg_data_i.value;
          CFG_SETPOINT_MAX: sp_max   = cfg_data_i.value;
          default: ;
        endcase
      end
      // Predict the status of an accepted event
      if (ev_valid_i && ev_ready_i) begin
        due_status_q.push_back(apply_event(ev_data_i));
      end
    end
    due_count_o      <= due_status_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- tb/hot_air_heater_mode_controller_test.sv -----
// Testbench top for the hot-air heater mode controller: clock, reset, events,
// settings and verdict. Depends on hahmc_pkg, hahmc_stream_if, hahmc_status_check.
module hot_air_heater_mode_controller_test import hahmc_pkg::*; ();

  localparam logic [2:0] CMD_SPARE     = 3'd7;
  localparam logic [2:0] CFG_SPARE     = 3'd5;
  localparam logic [2:0] CFG_SPARE_TOP = 3'd7;
  localparam int         CYCLE_LIMIT   = 400000;

  typedef enum int {
    PH_SETPOINT_UP,
    PH_SETPOINT_DOWN,
    PH_FAN,
    PH_MIXED
  } phase_e;

  typedef enum int {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  hahmc_stream_if #(.data_t(in_item_t))  ev_if ();
  hahmc_stream_if #(.data_t(out_item_t)) res_if ();
  hahmc_stream_if #(.data_t(cfg_item_t)) cfg_if ();

  int       due_count;
  int       mismatch_count;
  int       cycle_count = 0;
  int       events_sent = 0;
  int       burst_left  = 1;
  bit       ev_raised   = 1'b0;
  int       cur_thr     = COOL_THR_RESET;
  rx_mode_e rx_mode     = RX_STREAM;
  int       rx_left     = 0;

  hot_air_heater_mode_controller uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  hahmc_status_check status_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ev_valid_i       (ev_if.valid),
    .ev_ready_i       (ev_if.ready),
    .ev_data_i        (ev_if.data),
    .status_valid_i   (res_if.valid),
    .status_ready_i   (res_if.ready),
    .status_data_i    (res_if.data),
    .cfg_valid_i      (cfg_if.valid),
    .cfg_ready_i      (cfg_if.ready),
    .cfg_data_i       (cfg_if.data),
    .due_count_o      (due_count),
    .mismatch_count_o (mismatch_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Status receiver: switches among randomly chosen stall patterns
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 80);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: res_if.ready <= 1'b1;
      RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: res_if.ready <= ($urandom_range(0, 3) == 0);
      default:   res_if.ready <= (rx_left % 8) < 5;
    endcase
  end

  function automatic in_item_t make_event(input logic [2:0] cmd, input logic cw,
                                          input logic lifted, input logic lvl3,
                                          input logic [9:0] temp);
    in_item_t ev;
    ev.cmd              = cmd;
    ev.clockwise        = cw;
    ev.handle_lifted    = lifted;
    ev.menu_level_three = lvl3;
    ev.current_temp     = temp;
    return ev;
  endfunction

  // Temperature at or above the cooling threshold, or below it
  function automatic logic [9:0] pick_temp(input bit hot);
    case ($urandom_range(0, 7))
      0: return hot ? 10'd1023 : 10'd0;
      1: return hot ? 10'(cur_thr) : ((cur_thr == 0) ? 10'd0 : 10'(cur_thr - 1));
      default: begin
        if (hot) return 10'($urandom_range(1023, cur_thr));
        return (cur_thr == 0) ? 10'd0 : 10'($urandom_range(cur_thr - 1, 0));
      end
    endcase
  endfunction

  function automatic in_item_t random_event();
    return make_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      pick_temp(1'($urandom_range(0, 1))));
  endfunction

  // Drive one event beat; bursts of random length with random gaps between
  task automatic send_event(input in_item_t ev);
    int gap;
    ev_if.valid <= 1'b1;
    ev_if.data  <= ev;
    ev_raised = 1'b1;
    do @(posedge clk_i); while (!ev_if.ready);
    events_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        ev_if.valid <= 1'b0;
        ev_raised = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold events until every predicted status beat has arrived
  task automatic wait_results_done();
    if (ev_raised) begin
      ev_if.valid <= 1'b0;
      ev_raised = 1'b0;
    end
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write every settings register plus one unused index, back to back
  task automatic load_settings(input int thr, input int smin, input int smax,
                               input int fdef, input int sdef);
    cfg_item_t writes[6];
    writes[0] = '{index: CFG_COOL_THR,         value: 10'(thr)};
    writes[1] = '{index: CFG_SETPOINT_MIN,     value: 10'(smin)};
    writes[2] = '{index: CFG_SETPOINT_MAX,     value: 10'(smax)};
    writes[3] = '{index: CFG_FAN_DEFAULT,      value: 10'(fdef)};
    writes[4] = '{index: CFG_SETPOINT_DEFAULT, value: 10'(sdef)};
    writes[5] = '{index: 3'($urandom_range(CFG_SPARE_TOP, CFG_SPARE)),
                  value: 10'($urandom_range(0, 1023))};
    cur_thr = thr;
    foreach (writes[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= writes[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // One use of the heater: power up, knobs, maybe a nap on the stand,
  // power down and cooling polls until it has cooled
  task automatic run_session();
    int n;
    send_event(make_event(($urandom_range(0, 3) == 0) ? CMD_FIX : CMD_ON,
                          1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)),
                          pick_temp(1'($urandom_range(0, 1)))));
    n = $urandom_range(0, 3);
    repeat (n) begin
      send_event(make_event(($urandom_range(0, 1) != 0) ? CMD_FAN_KNOB : CMD_TEMP_KNOB,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), pick_temp(1'($urandom_range(0, 1)))));
    end
    if ($urandom_range(0, 1) != 0) begin
      send_event(make_event(CMD_STAND, 1'($urandom_range(0, 1)), 1'b0,
                            1'($urandom_range(0, 1)), pick_temp(1'b1)));
      n = $urandom_range(0, 3);
      repeat (n) begin
        send_event(make_event(($urandom_range(0, 1) != 0) ? CMD_STAND : CMD_COOL_POLL,
                              1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)),
                              pick_temp(1'($urandom_range(0, 1)))));
      end
      if ($urandom_range(0, 3) != 0) begin
        send_event(make_event(CMD_STAND, 1'($urandom_range(0, 1)), 1'b1,
                              1'($urandom_range(0, 1)),
                              pick_temp(1'($urandom_range(0, 1)))));
      end
    end
    send_event(make_event(($urandom_range(0, 3) == 0) ? CMD_FIX : CMD_OFF,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_temp($urandom_range(0, 3) != 0)));
    n = $urandom_range(0, 4);
    repeat (n) begin
      send_event(make_event(CMD_COOL_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), pick_temp(1'b1)));
    end
    send_event(make_event(CMD_COOL_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_temp(1'b0)));
  endtask

  task automatic run_phase(input phase_e kind, input int count);
    int   first;
    logic up;
    first = events_sent;
    while (events_sent - first < count) begin
      up = (events_sent - first) >= count / 2;
      case (kind)
        PH_SETPOINT_UP, PH_SETPOINT_DOWN: begin
          if ($urandom_range(0, 15) != 0) begin
            send_event(make_event(CMD_TEMP_KNOB, kind == PH_SETPOINT_UP,
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  10'($urandom_range(0, 1023))));
          end else begin
            send_event(random_event());
          end
        end
        PH_FAN: begin
          if ($urandom_range(0, 15) != 0) begin
            send_event(make_event(CMD_FAN_KNOB, up, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023))));
          end else begin
            send_event(random_event());
          end
        end
        default: begin
          if ($urandom_range(0, 3) != 0) run_session();
          else send_event(random_event());
        end
      endcase
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    ev_if.valid  <= 1'b0;
    ev_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Opening events at the power-up settings (threshold 50)
    send_event(make_event(CMD_SPARE, 1'b1, 1'b1, 1'b1, 10'd1023));
    send_event(make_event(CMD_COOL_POLL, 1'b0, 1'b0, 1'b0, 10'd0));
    send_event(make_event(CMD_STAND, 1'b0, 1'b1, 1'b0, 10'd0));
    send_event(make_event(CMD_ON, 1'b0, 1'b0, 1'b0, 10'd512));
    send_event(make_event(CMD_FAN_KNOB, 1'b1, 1'b0, 1'b0, 10'd300));
    send_event(make_event(CMD_FAN_KNOB, 1'b0, 1'b1, 1'b1, 10'd300));
    send_event(make_event(CMD_TEMP_KNOB, 1'b1, 1'b0, 1'b0, 10'd300));
    send_event(make_event(CMD_TEMP_KNOB, 1'b0, 1'b1, 1'b0, 10'd300));
    // Sleep on the stand, fan knob against its top, cool down asleep, blink,
    // then wake on lift
    send_event(make_event(CMD_STAND, 1'b0, 1'b0, 1'b0, 10'd300));
    send_event(make_event(CMD_FAN_KNOB, 1'b1, 1'b0, 1'b0, 10'd300));
    send_event(make_event(CMD_STAND, 1'b0, 1'b0, 1'b1, 10'd300));
    send_event(make_event(CMD_COOL_POLL, 1'b0, 1'b0, 1'b0, 10'd1023));
    send_event(make_event(CMD_COOL_POLL, 1'b0, 1'b0, 1'b0, 10'd0));
    send_event(make_event(CMD_STAND, 1'b1, 1'b0, 1'b0, 10'd0));
    send_event(make_event(CMD_STAND, 1'b0, 1'b1, 1'b0, 10'd0));
    // Fixed power on, then off exactly at the threshold with the handle lifted
    send_event(make_event(CMD_FIX, 1'b0, 1'b0, 1'b0, 10'd100));
    send_event(make_event(CMD_FIX, 1'b0, 1'b1, 1'b0, 10'd50));
    send_event(make_event(CMD_COOL_POLL, 1'b0, 1'b0, 1'b0, 10'd49));
    // Power off cold, hot on the stand, and hot in menu level three
    send_event(make_event(CMD_ON, 1'b1, 1'b1, 1'b1, 10'd0));
    send_event(make_event(CMD_OFF, 1'b0, 1'b1, 1'b1, 10'd0));
    send_event(make_event(CMD_ON, 1'b0, 1'b0, 1'b0, 10'd700));
    send_event(make_event(CMD_OFF, 1'b0, 1'b0, 1'b0, 10'd1023));
    send_event(make_event(CMD_ON, 1'b0, 1'b0, 1'b0, 10'd700));
    send_event(make_event(CMD_OFF, 1'b0, 1'b0, 1'b1, 10'd1023));
    send_event(make_event(CMD_COOL_POLL, 1'b1, 1'b1, 1'b1, 10'd50));
    send_event(make_event(CMD_COOL_POLL, 1'b1, 1'b1, 1'b1, 10'd0));
    wait_results_done();

    // Walk the setpoint down to zero and hold it there; almost any temperature is cool
    load_settings(1023, 0, 1023, 100, 0);
    run_phase(PH_SETPOINT_DOWN, 50);
    wait_results_done();

    // Widest setpoint span: climb into the top clamp, cooling never ends
    load_settings(0, 0, 1023, 20, 1023);
    run_phase(PH_SETPOINT_UP, 230);
    wait_results_done();

    // Setpoint pinned; walk the fan down, then up
    load_settings(50, 600, 600, 60, 200);
    run_phase(PH_FAN, 50);
    wait_results_done();

    // Realistic sessions
    load_settings($urandom_range(30, 300), $urandom_range(0, 400), $urandom_range(400, 1023),
                  $urandom_range(20, 100), $urandom_range(0, 1023));
    run_phase(PH_MIXED, 25);
    wait_results_done();

    // Any settings, including an empty setpoint span
    load_settings($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(20, 100), $urandom_range(0, 1023));
    run_phase(PH_MIXED, 20);
    wait_results_done();
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
